### rtl/core/vdm_pkg.sv
// Shared types and constants for the varicode DBPSK modulator.
package vdm_pkg;

    // Message store geometry
    localparam int MSG_DEPTH    = 256;
    localparam int MSG_ADDR_W   = 8;
    localparam int MSG_LEN_W    = 9;

    // Varicode word geometry
    localparam int CODE_MAX     = 10;
    localparam int CODE_LEN_W   = 4;

    // Bit timing and framing
    localparam int PASS_ZEROS      = 32;
    localparam int CHAR_GAP        = 2;
    localparam int CYCLES_PER_BIT  = 32;
    localparam int SAMPLES_PER_BIT = 2;

    // Counter and accumulator widths
    localparam int PHASE_W    = 32;
    localparam int CODE_POS_W = 7;
    localparam int CYC_CNT_W  = 7;
    localparam int SMP_CNT_W  = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_MSG_LENGTH = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } item_kind_t;

    typedef enum logic {
        MODE_CARRIER = 1'b0,
        MODE_DIRECT  = 1'b1
    } out_mode_t;

    typedef logic signed [CODE_POS_W-1:0] code_pos_t;
    typedef logic signed [CYC_CNT_W-1:0]  cyc_cnt_t;
    typedef logic signed [SMP_CNT_W-1:0]  smp_cnt_t;

    // Input transaction payload
    typedef struct packed {
        logic                  kind;
        logic [MSG_ADDR_W-1:0] entry_index;
        logic [CODE_MAX-1:0]   code_bits;
        logic [CODE_LEN_W-1:0] code_length;
    } item_t;

    // Output transaction payload
    typedef struct packed {
        logic line_level;
        logic bit_started;
    } result_t;

    // One stored character
    typedef struct packed {
        logic [CODE_LEN_W-1:0] length;
        logic [CODE_MAX-1:0]   code;
    } store_entry_t;

    // Write request into the message store
    typedef struct packed {
        logic                  en;
        logic [MSG_ADDR_W-1:0] addr;
        store_entry_t          data;
    } store_wr_t;

endpackage

### rtl/core/vdm_msg_store.sv
// Message character store with one write port and a registered, write-forwarded read.
module vdm_msg_store (
    input  logic                           clk,
    input  vdm_pkg::store_wr_t             wr,
    input  logic [vdm_pkg::MSG_ADDR_W-1:0] rd_addr,
    output vdm_pkg::store_entry_t          rd_data
);

    vdm_pkg::store_entry_t mem [vdm_pkg::MSG_DEPTH];
    vdm_pkg::store_entry_t rd_data_reg;

    // Write the entry; read the next address, forwarding a same-cycle write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/varicode_dbpsk_modulator.sv
// Top level of the repeating-message varicode DBPSK modulator.
//
// Usage:
//   item channel   : item_valid/item_ready with an item_t payload. A load
//                    transaction writes one varicode word into the message
//                    store and gives no result; a tick transaction gives one
//                    result (line level and bit-start flag).
//   result channel : result_valid/result_ready with a result_t payload.
//   cfg channel    : cfg_valid/cfg_ready, cfg_index selects mode, phase step
//                    or message length; write only while the block is idle.
// Path: an accepted tick is held in the input register and its result is
//   registered in the result register when that slot is free or draining.
// Throughput: one transaction per cycle unless a held result waits on
//   result_ready; set by the single-pass update from the input register to
//   the result register. A prefetched store read never stalls the flow.
// Reset: modulator state returns to polarity 0, phase 0, counters at minus
//   one and message position 0; the message store is not cleared, and
//   entries must be loaded before they are sent.
// Stall: a valid result stays in the result register while result_ready is
//   low; the next tick waits in the input register and item_ready drops.
//   Load transactions still pass, since they give no result.
module varicode_dbpsk_modulator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  vdm_pkg::item_t                       item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output vdm_pkg::result_t                     result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vdm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vdm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Configuration registers
    logic                           mode_reg;
    logic [vdm_pkg::PHASE_W-1:0]    phase_step_reg;
    logic [vdm_pkg::MSG_LEN_W-1:0]  msg_length_reg, msg_length_next;

    // Input and result registers
    logic                           in_valid_reg;
    vdm_pkg::item_t                 in_reg;
    logic                           out_valid_reg;
    vdm_pkg::result_t               out_reg, out_next;

    // Modulator state
    logic                           polarity_reg, polarity_next;
    logic [vdm_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    vdm_pkg::cyc_cnt_t              cycle_count_reg, cycle_count_next;
    vdm_pkg::smp_cnt_t              sample_count_reg, sample_count_next;
    logic [vdm_pkg::MSG_LEN_W-1:0]  msg_pos_reg, msg_pos_next;
    vdm_pkg::code_pos_t             code_pos_reg, code_pos_next;
    logic [vdm_pkg::CODE_MAX-1:0]   cur_code_reg, cur_code_next;
    logic [vdm_pkg::CODE_LEN_W-1:0] cur_len_reg, cur_len_next;

    // Handshake and work signals
    logic                           cfg_wr;
    logic                           is_tick;
    logic                           advance;
    logic                           do_tick;
    logic                           start_bit;
    logic                           tx_bit;
    logic [vdm_pkg::CODE_LEN_W-1:0] bit_sel;
    logic [vdm_pkg::MSG_LEN_W-1:0]  len_eff, len_eff_next;
    logic [vdm_pkg::PHASE_W:0]      phase_sum;
    logic [vdm_pkg::CODE_LEN_W-1:0] load_len;
    vdm_pkg::store_wr_t             st_wr;
    logic [vdm_pkg::MSG_ADDR_W-1:0] st_rd_addr;
    vdm_pkg::store_entry_t          st_rd_data;

    // Loads always move through; ticks when the result slot is free or draining
    assign is_tick    = (in_reg.kind == vdm_pkg::KIND_TICK);
    assign advance    = in_valid_reg && (!is_tick || !out_valid_reg || result_ready);
    assign do_tick    = advance && is_tick;
    assign item_ready = !in_valid_reg || advance;
    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;

    // Hold the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_reg <= item;
        end
    end

    // Configuration writes
    always_comb
    begin
        msg_length_next = msg_length_reg;
        if (cfg_wr && (cfg_index == vdm_pkg::CFG_MSG_LENGTH))
        begin
            msg_length_next = cfg_data[vdm_pkg::MSG_LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= vdm_pkg::MODE_CARRIER;
            phase_step_reg <= '0;
            msg_length_reg <= '0;
        end
        else
        begin
            if (cfg_wr && (cfg_index == vdm_pkg::CFG_MODE))
            begin
                mode_reg <= cfg_data[0];
            end
            if (cfg_wr && (cfg_index == vdm_pkg::CFG_PHASE_STEP))
            begin
                phase_step_reg <= cfg_data[vdm_pkg::PHASE_W-1:0];
            end
            msg_length_reg <= msg_length_next;
        end
    end

    // Clamp message length to the store depth
    assign len_eff = (msg_length_reg > vdm_pkg::MSG_LEN_W'(vdm_pkg::MSG_DEPTH))
                   ? vdm_pkg::MSG_LEN_W'(vdm_pkg::MSG_DEPTH) : msg_length_reg;
    assign len_eff_next = (msg_length_next > vdm_pkg::MSG_LEN_W'(vdm_pkg::MSG_DEPTH))
                        ? vdm_pkg::MSG_LEN_W'(vdm_pkg::MSG_DEPTH) : msg_length_next;

    // Store write from a load transaction, length clamped to the word size
    assign load_len = (in_reg.code_length > vdm_pkg::CODE_LEN_W'(vdm_pkg::CODE_MAX))
                    ? vdm_pkg::CODE_LEN_W'(vdm_pkg::CODE_MAX) : in_reg.code_length;

    always_comb
    begin
        st_wr.en        = advance && !is_tick;
        st_wr.addr      = in_reg.entry_index;
        st_wr.data.length = load_len;
        st_wr.data.code   = in_reg.code_bits;
    end

    // Prefetch the character that the next word boundary would load
    assign st_rd_addr = (msg_pos_next >= len_eff_next)
                      ? '0 : msg_pos_next[vdm_pkg::MSG_ADDR_W-1:0];

    vdm_msg_store u_store (
        .clk     (clk),
        .wr      (st_wr),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // Decide whether this tick starts a bit
    always_comb
    begin
        if (mode_reg == vdm_pkg::MODE_CARRIER)
        begin
            start_bit = (cycle_count_reg >= vdm_pkg::cyc_cnt_t'(vdm_pkg::CYCLES_PER_BIT));
        end
        else
        begin
            start_bit = (sample_count_reg >= vdm_pkg::smp_cnt_t'(vdm_pkg::SAMPLES_PER_BIT));
        end
    end

    assign bit_sel = cur_len_reg - vdm_pkg::CODE_LEN_W'(1)
                   - code_pos_reg[vdm_pkg::CODE_LEN_W-1:0];

    // Pick the next bit and advance the framing state
    always_comb
    begin
        tx_bit        = 1'b0;
        code_pos_next = code_pos_reg;
        msg_pos_next  = msg_pos_reg;
        cur_code_next = cur_code_reg;
        cur_len_next  = cur_len_reg;
        if (do_tick && start_bit)
        begin
            priority if (code_pos_reg[vdm_pkg::CODE_POS_W-1])
            begin
                code_pos_next = code_pos_reg + vdm_pkg::code_pos_t'(1);
            end
            else if (code_pos_reg < vdm_pkg::code_pos_t'({1'b0, cur_len_reg}))
            begin
                tx_bit        = cur_code_reg[bit_sel];
                code_pos_next = code_pos_reg + vdm_pkg::code_pos_t'(1);
            end
            else if (msg_pos_reg >= len_eff)
            begin
                code_pos_next = vdm_pkg::code_pos_t'(-vdm_pkg::PASS_ZEROS);
                if (len_eff != '0)
                begin
                    cur_code_next = st_rd_data.code;
                    cur_len_next  = st_rd_data.length;
                    msg_pos_next  = vdm_pkg::MSG_LEN_W'(1);
                end
                else
                begin
                    cur_code_next = '0;
                    cur_len_next  = '0;
                    msg_pos_next  = '0;
                end
            end
            else
            begin
                cur_code_next = st_rd_data.code;
                cur_len_next  = st_rd_data.length;
                msg_pos_next  = msg_pos_reg + vdm_pkg::MSG_LEN_W'(1);
                code_pos_next = vdm_pkg::code_pos_t'(-vdm_pkg::CHAR_GAP);
            end
        end
    end

    // Update polarity, counters, carrier phase and the line level
    assign phase_sum = {1'b0, phase_reg} + {1'b0, phase_step_reg};

    always_comb
    begin
        polarity_next     = polarity_reg;
        cycle_count_next  = cycle_count_reg;
        sample_count_next = sample_count_reg;
        phase_next        = phase_reg;
        out_next          = out_reg;
        if (do_tick)
        begin
            if (start_bit)
            begin
                polarity_next     = polarity_reg ^ ~tx_bit;
                cycle_count_next  = '0;
                sample_count_next = '0;
            end
            out_next.bit_started = start_bit;
            if (mode_reg == vdm_pkg::MODE_CARRIER)
            begin
                out_next.line_level =
                    (phase_reg > {1'b1, {(vdm_pkg::PHASE_W-1){1'b0}}})
                    ? polarity_next : ~polarity_next;
                phase_next = phase_sum[vdm_pkg::PHASE_W-1:0];
                if (phase_sum[vdm_pkg::PHASE_W])
                begin
                    cycle_count_next = cycle_count_next + vdm_pkg::cyc_cnt_t'(1);
                end
            end
            else
            begin
                sample_count_next   = sample_count_next + vdm_pkg::smp_cnt_t'(1);
                out_next.line_level = polarity_next;
            end
        end
    end

    // Register modulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg     <= 1'b0;
            phase_reg        <= '0;
            cycle_count_reg  <= '1;
            sample_count_reg <= '1;
            msg_pos_reg      <= '0;
            code_pos_reg     <= '0;
            cur_code_reg     <= '0;
            cur_len_reg      <= '0;
        end
        else
        begin
            polarity_reg     <= polarity_next;
            phase_reg        <= phase_next;
            cycle_count_reg  <= cycle_count_next;
            sample_count_reg <= sample_count_next;
            msg_pos_reg      <= msg_pos_next;
            code_pos_reg     <= code_pos_next;
            cur_code_reg     <= cur_code_next;
            cur_len_reg      <= cur_len_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
